FILE: sv/wud_pkg.sv
// wud_pkg: shared constants and controller/datapath command types for the
// 256-bit unsigned divider. No dependencies.
package wud_pkg;

   localparam int LimbW  = 64;
   localparam int Limbs  = 4;
   localparam int Width  = LimbW * Limbs;
   localparam int CountW = $clog2(Width);

   typedef logic [LimbW-1:0]  limb_type;
   typedef logic [Width-1:0]  word_type;
   typedef logic [CountW-1:0] count_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // take a new item into the working registers
      logic step;     // one shift-subtract iteration
      logic capture;  // copy the finished result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic den_zero; // working divisor is zero
   } status_type;

endpackage

FILE: sv/wud_if.sv
// Channel interfaces for the 256-bit divider: request (operands) and
// response (quotient, remainder, flag). Depends on wud_pkg.
interface wud_req_if;
   logic               valid;
   logic               ready;
   wud_pkg::limb_type  dividend_w0;
   wud_pkg::limb_type  dividend_w1;
   wud_pkg::limb_type  dividend_w2;
   wud_pkg::limb_type  dividend_w3;
   wud_pkg::limb_type  divisor_w0;
   wud_pkg::limb_type  divisor_w1;
   wud_pkg::limb_type  divisor_w2;
   wud_pkg::limb_type  divisor_w3;

   modport source (
      output valid, dividend_w0, dividend_w1, dividend_w2, dividend_w3,
             divisor_w0, divisor_w1, divisor_w2, divisor_w3,
      input  ready
   );
   modport sink (
      input  valid, dividend_w0, dividend_w1, dividend_w2, dividend_w3,
             divisor_w0, divisor_w1, divisor_w2, divisor_w3,
      output ready
   );
endinterface

interface wud_rsp_if;
   logic               valid;
   logic               ready;
   wud_pkg::limb_type  quotient_w0;
   wud_pkg::limb_type  quotient_w1;
   wud_pkg::limb_type  quotient_w2;
   wud_pkg::limb_type  quotient_w3;
   wud_pkg::limb_type  remainder_w0;
   wud_pkg::limb_type  remainder_w1;
   wud_pkg::limb_type  remainder_w2;
   wud_pkg::limb_type  remainder_w3;
   logic               zero_divisor;

   modport source (
      output valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
             remainder_w0, remainder_w1, remainder_w2, remainder_w3, zero_divisor,
      input  ready
   );
   modport sink (
      input  valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
             remainder_w0, remainder_w1, remainder_w2, remainder_w3, zero_divisor,
      output ready
   );
endinterface

FILE: sv/wud_datapath.sv
// wud_datapath: working registers, the shared 257-bit subtractor and the
// output register of the divider. Depends on wud_pkg.
module wud_datapath (
   input  logic                clock,
   input  wud_pkg::cmd_type    cmd,
   input  wud_pkg::word_type   dividend,
   input  wud_pkg::word_type   divisor,
   output wud_pkg::status_type status,
   output wud_pkg::word_type   quotient,
   output wud_pkg::word_type   remainder,
   output logic                zero_divisor
);

   // num_ff shifts dividend bits out at the top and quotient bits in at the bottom
   wud_pkg::word_type num_ff, num_in;
   wud_pkg::word_type den_ff, den_in;
   wud_pkg::word_type rem_ff, rem_in;
   wud_pkg::word_type quo_out_ff, quo_out_in;
   wud_pkg::word_type rem_out_ff, rem_out_in;
   logic              zero_out_ff, zero_out_in;

   logic [wud_pkg::Width:0] shifted;
   logic [wud_pkg::Width:0] diff;
   logic                    take;

   assign status.den_zero = ~|den_ff;

   // remainder stays below the divisor, so shifted < 2*den and the borrow
   // bit alone decides the quotient bit
   assign shifted = {rem_ff, num_ff[wud_pkg::Width-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign take    = ~diff[wud_pkg::Width];

   always_comb begin
      num_in      = num_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      quo_out_in  = quo_out_ff;
      rem_out_in  = rem_out_ff;
      zero_out_in = zero_out_ff;
      if (cmd.load) begin
         num_in = dividend;
         den_in = divisor;
         rem_in = '0;
      end else if (cmd.step) begin
         num_in = {num_ff[wud_pkg::Width-2:0], take};
         rem_in = take ? diff[wud_pkg::Width-1:0] : shifted[wud_pkg::Width-1:0];
      end
      if (cmd.capture) begin
         zero_out_in = status.den_zero;
         // with a zero divisor no step ran and num_ff still holds the dividend
         if (status.den_zero) begin
            quo_out_in = '0;
            rem_out_in = num_ff;
         end else begin
            quo_out_in = num_ff;
            rem_out_in = rem_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_out_ff  <= quo_out_in;
      rem_out_ff  <= rem_out_in;
      zero_out_ff <= zero_out_in;
   end

   assign quotient     = quo_out_ff;
   assign remainder    = rem_out_ff;
   assign zero_divisor = zero_out_ff;

endmodule

FILE: sv/wud_ctrl.sv
// wud_ctrl: sequencing state machine of the divider: step counter, handshakes
// and output-register valid. Depends on wud_pkg.
module wud_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wud_pkg::status_type status,
   output wud_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   wud_pkg::count_type  count_ff, count_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign out_free  = ~out_valid_ff | rsp_ready;

   assign cmd.load    = req_valid & req_ready;
   assign cmd.step    = (state_ff == ST_RUN) & ~status.den_zero;
   assign cmd.capture = (state_ff == ST_FINISH) & out_free;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_RUN;
               count_in = '1;
            end
         end
         ST_RUN: begin
            if (status.den_zero || count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: sv/wide_unsigned_divider.sv
// 256-bit unsigned divider, restoring shift-subtract, one quotient bit per
// cycle. Depends on wud_pkg, wud_if, wud_ctrl and wud_datapath.
//
// An accepted item reaches the output register as follows: the operands are
// loaded, 256 iterations of the single 257-bit subtractor run (one quotient
// bit each, most significant first) and the output register is written once
// it is free. A zero divisor skips the iterations and returns quotient zero,
// the dividend as remainder and zero_divisor set. One item is worked at a time;
// the next item is accepted as soon as the previous one has moved to the
// output register, even while that result still waits on rsp_ch.ready.
module wide_unsigned_divider (
   input  logic       clock,
   input  logic       reset,
   wud_req_if.sink    req_ch,
   wud_rsp_if.source  rsp_ch
);

   wud_pkg::cmd_type    cmd;
   wud_pkg::status_type status;
   wud_pkg::word_type   dividend;
   wud_pkg::word_type   divisor;
   wud_pkg::word_type   quotient;
   wud_pkg::word_type   remainder;
   logic                zero_divisor;

   assign dividend = {req_ch.dividend_w3, req_ch.dividend_w2,
                      req_ch.dividend_w1, req_ch.dividend_w0};
   assign divisor  = {req_ch.divisor_w3, req_ch.divisor_w2,
                      req_ch.divisor_w1, req_ch.divisor_w0};

   wud_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wud_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .dividend     (dividend),
      .divisor      (divisor),
      .status       (status),
      .quotient     (quotient),
      .remainder    (remainder),
      .zero_divisor (zero_divisor)
   );

   assign rsp_ch.quotient_w0  = quotient[63:0];
   assign rsp_ch.quotient_w1  = quotient[127:64];
   assign rsp_ch.quotient_w2  = quotient[191:128];
   assign rsp_ch.quotient_w3  = quotient[255:192];
   assign rsp_ch.remainder_w0 = remainder[63:0];
   assign rsp_ch.remainder_w1 = remainder[127:64];
   assign rsp_ch.remainder_w2 = remainder[191:128];
   assign rsp_ch.remainder_w3 = remainder[255:192];
   assign rsp_ch.zero_divisor = zero_divisor;

endmodule

FILE: sv/wud_checker.sv
// wud_checker: port-level assertions for wide_unsigned_divider, attached by
// the bind below. Depends on wud_pkg.
module wud_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wud_pkg::word_type quotient,
   input logic              zero_divisor
);

   // a held result must not change or vanish while stalled
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(quotient) && $stable(zero_divisor);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("response dropped or changed while stalled");

   // one item at a time: no second accept right after an accept
   property p_busy_after_accept;
      @(posedge clock) disable iff (reset)
         req_valid && req_ready |=> !req_ready;
   endproperty
   a_busy_after_accept: assert property (p_busy_after_accept)
      else $error("request ready right after an accept");

   // zero divisor result carries a zero quotient
   property p_zero_quotient;
      @(posedge clock) disable iff (reset)
         rsp_valid && zero_divisor |-> quotient == '0;
   endproperty
   a_zero_quotient: assert property (p_zero_quotient)
      else $error("nonzero quotient with zero divisor");

   // after reset: no response pending, ready for an item
   property p_reset_state;
      @(posedge clock) reset |=> !rsp_valid && req_ready;
   endproperty
   a_reset_state: assert property (p_reset_state) else $error("bad state after reset");

endmodule

bind wide_unsigned_divider wud_checker u_wud_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .quotient     ({rsp_ch.quotient_w3, rsp_ch.quotient_w2,
                   rsp_ch.quotient_w1, rsp_ch.quotient_w0}),
   .zero_divisor (rsp_ch.zero_divisor)
);
